>>> rtl/pplm_pkg.sv
package pplm_pkg;

  // Output scaling: level_db counts 2^-DB_FRAC_BITS dB steps.
  localparam int DB_FRAC_BITS = 8;

  localparam int SAMPLE_W = 32;
  localparam int LEVEL_W  = 16;
  localparam int CFG_W    = 2;

  // log2 datapath: 5-bit integer part, LOG_FRAC fraction bits.
  localparam int MSB_W    = 5;
  localparam int LOG_FRAC = 24;
  localparam int LOG_W    = MSB_W + LOG_FRAC;

  // 20*log10(2) in Q.28
  localparam int                 OCT_W             = 31;
  localparam logic [OCT_W-1:0]   DB_PER_OCTAVE_Q28 = 31'd1616142483;
  localparam int                 PROD_W            = LOG_W + OCT_W;
  localparam int                 DB_SHIFT          = 52 - DB_FRAC_BITS;

  // Full-scale reference: log2(2^31)
  localparam logic [LOG_W-1:0] LOG_REF = {5'd31, {LOG_FRAC{1'b0}}};

  localparam logic [SAMPLE_W-1:0] FULL_SCALE_SAT = '1;
  // 1e-6 of full scale in Q1.31
  localparam logic [SAMPLE_W-1:0] SILENT_LIMIT   = 32'd2147;

  localparam logic signed [31:0] SILENT_LEVEL_FULL = -32'sd120 * (32'sd1 <<< DB_FRAC_BITS);
  localparam logic [LEVEL_W-1:0] SILENT_LEVEL      = SILENT_LEVEL_FULL[LEVEL_W-1:0];

  typedef enum logic [CFG_W-1:0] {
    FMT_FLOAT32 = 2'd0,
    FMT_INT16   = 2'd1,
    FMT_INT32   = 2'd2,
    FMT_UINT8   = 2'd3
  } fmt_e;

  localparam fmt_e FMT_RESET = FMT_INT16;

  // Buffer-end job leaving the peak tracker
  typedef struct packed {
    logic                valid;
    logic                silent;
    logic [SAMPLE_W-1:0] peak;
  } job_t;

  // log2 result leaving the log pipeline
  typedef struct packed {
    logic             valid;
    logic             silent;
    logic [LOG_W-1:0] log2;
  } log_t;

  // Payload of one squaring stage
  typedef struct packed {
    logic                silent;
    logic [MSB_W-1:0]    msb;
    logic [LOG_FRAC-1:0] frac;
    logic [SAMPLE_W-1:0] x;
  } sq_t;

endpackage

>>> rtl/pplm_norm.sv
module pplm_norm (
  input  pplm_pkg::fmt_e                fmt_i,
  input  logic [pplm_pkg::SAMPLE_W-1:0] bits_i,
  output logic [pplm_pkg::SAMPLE_W-1:0] mag_o
);
  import pplm_pkg::*;

  logic [7:0]  f_exp;
  logic [23:0] f_man;
  logic [7:0]  up_amt;
  logic [7:0]  dn_amt;
  logic [SAMPLE_W-1:0] f_mag;
  logic [15:0] s16;
  logic [15:0] a16;
  logic [7:0]  u8;
  logic [7:0]  a8;

  // float32 -> floor(|f| * 2^31), saturating at 2.0 / inf / NaN
  always_comb begin
    f_exp  = bits_i[30:23];
    f_man  = {1'b1, bits_i[22:0]};
    up_amt = f_exp - 8'd119;
    dn_amt = 8'd119 - f_exp;
    if (f_exp >= 8'd128) begin
      f_mag = FULL_SCALE_SAT;
    end else if (f_exp == 8'd0) begin
      f_mag = '0;
    end else if (f_exp >= 8'd119) begin
      f_mag = {8'b0, f_man} << up_amt[3:0];
    end else if (dn_amt >= 8'd24) begin
      f_mag = '0;
    end else begin
      f_mag = {8'b0, f_man} >> dn_amt[4:0];
    end
  end

  always_comb begin
    s16 = bits_i[15:0];
    a16 = s16[15] ? (16'd0 - s16) : s16;
    u8  = bits_i[7:0];
    a8  = u8[7] ? (u8 - 8'd128) : (8'd128 - u8);
  end

  always_comb begin
    unique case (fmt_i)
      FMT_FLOAT32: mag_o = f_mag;
      FMT_INT16:   mag_o = {a16, 16'b0};
      FMT_INT32:   mag_o = bits_i[31] ? (32'd0 - bits_i) : bits_i;
      FMT_UINT8:   mag_o = {a8, 24'b0};
      default:     mag_o = '0;
    endcase
  end

endmodule

>>> rtl/pplm_peak.sv
module pplm_peak (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          s_valid_i,
  input  logic [pplm_pkg::SAMPLE_W-1:0] s_data_i,
  input  logic                          s_last_i,
  input  pplm_pkg::fmt_e                fmt_i,
  output pplm_pkg::job_t                job_o
);
  import pplm_pkg::*;

  logic                in_valid_q;
  logic [SAMPLE_W-1:0] in_data_q;
  logic                in_last_q;
  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W-1:0] peak_q;
  logic [SAMPLE_W-1:0] peak_new;
  logic                job_valid_q;
  logic                job_silent_q;
  logic [SAMPLE_W-1:0] job_peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv_i) begin
      in_valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && s_valid_i) begin
      in_data_q <= s_data_i;
      in_last_q <= s_last_i;
    end
  end

  pplm_norm u_norm (
    .fmt_i  (fmt_i),
    .bits_i (in_data_q),
    .mag_o  (mag)
  );

  assign peak_new = (mag > peak_q) ? mag : peak_q;

  // The final beat of a buffer is folded in before the peak is handed off.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q      <= '0;
      job_valid_q <= 1'b0;
    end else if (adv_i) begin
      job_valid_q <= in_valid_q && in_last_q;
      if (in_valid_q) begin
        peak_q <= in_last_q ? '0 : peak_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && in_valid_q && in_last_q) begin
      job_peak_q   <= peak_new;
      job_silent_q <= (peak_new <= SILENT_LIMIT);
    end
  end

  assign job_o.valid  = job_valid_q;
  assign job_o.silent = job_silent_q;
  assign job_o.peak   = job_peak_q;

endmodule

>>> rtl/pplm_log2.sv
module pplm_log2 (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  pplm_pkg::job_t job_i,
  output pplm_pkg::log_t log_o
);
  import pplm_pkg::*;

  // Leading-one stage
  logic                lz_valid_q;
  logic                lz_silent_q;
  logic [SAMPLE_W-1:0] lz_peak_q;
  logic [MSB_W-1:0]    lz_msb_q;
  logic [MSB_W-1:0]    msb_d;

  // Stage 0 holds the normalized mantissa; stage i has resolved i fraction bits.
  logic [LOG_FRAC:0]   sq_valid_q;
  sq_t                 sq_q [LOG_FRAC+1];
  sq_t                 sh_d;

  always_comb begin
    msb_d = '0;
    for (int i = 0; i < SAMPLE_W; i++) begin
      if (job_i.peak[i]) begin
        msb_d = MSB_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lz_valid_q <= 1'b0;
    end else if (adv_i) begin
      lz_valid_q <= job_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lz_silent_q <= job_i.silent;
      lz_peak_q   <= job_i.peak;
      lz_msb_q    <= msb_d;
    end
  end

  // Shift so the leading one sits at bit 31 (shift by 31 - msb).
  always_comb begin
    sh_d.silent = lz_silent_q;
    sh_d.msb    = lz_msb_q;
    sh_d.frac   = '0;
    sh_d.x      = lz_peak_q << (~lz_msb_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q[0] <= 1'b0;
    end else if (adv_i) begin
      sq_valid_q[0] <= lz_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sq_q[0] <= sh_d;
    end
  end

  // One squaring per stage: x in [2^31, 2^32); x^2 >> 31 >= 2^32 yields a one bit.
  for (genvar i = 1; i <= LOG_FRAC; i++) begin : g_sq
    logic [2*SAMPLE_W-1:0] sq;
    logic [SAMPLE_W:0]     t;
    sq_t                   nxt;

    always_comb begin
      nxt = sq_q[i-1];
      sq  = {{SAMPLE_W{1'b0}}, sq_q[i-1].x} * {{SAMPLE_W{1'b0}}, sq_q[i-1].x};
      t   = sq[2*SAMPLE_W-1:SAMPLE_W-1];
      if (t[SAMPLE_W]) begin
        nxt.frac[LOG_FRAC-i] = 1'b1;
        nxt.x                = t[SAMPLE_W:1];
      end else begin
        nxt.x = t[SAMPLE_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_valid_q[i] <= 1'b0;
      end else if (adv_i) begin
        sq_valid_q[i] <= sq_valid_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        sq_q[i] <= nxt;
      end
    end
  end

  assign log_o.valid  = sq_valid_q[LOG_FRAC];
  assign log_o.silent = sq_q[LOG_FRAC].silent;
  assign log_o.log2   = {sq_q[LOG_FRAC].msb, sq_q[LOG_FRAC].frac};

endmodule

>>> rtl/pplm_db.sv
module pplm_db (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pplm_pkg::log_t               log_i,
  input  logic                         m_ready_i,
  output logic                         m_valid_o,
  output logic [pplm_pkg::LEVEL_W-1:0] m_level_o,
  output logic                         m_silent_o,
  output logic                         adv_o
);
  import pplm_pkg::*;

  logic             d_valid_q;
  logic             d_silent_q;
  logic             d_neg_q;
  logic [LOG_W-1:0] d_q;
  logic             neg_d;
  logic [LOG_W-1:0] dist_d;

  logic              p_valid_q;
  logic              p_silent_q;
  logic              p_neg_q;
  logic [PROD_W-1:0] p_q;
  logic [PROD_W-1:0] prod_d;

  logic [PROD_W:0]    rsum;
  logic [PROD_W:0]    rsh;
  logic [LEVEL_W-1:0] rmag;
  logic [LEVEL_W-1:0] level_d;

  logic               out_valid_q;
  logic [LEVEL_W-1:0] out_level_q;
  logic               out_silent_q;
  logic               out_load;

  // Whole pipeline holds only when a finished level cannot enter the output register.
  assign adv_o    = !(p_valid_q && out_valid_q && !m_ready_i);
  assign out_load = !out_valid_q || m_ready_i;

  assign neg_d  = log_i.log2 < LOG_REF;
  assign dist_d = neg_d ? (LOG_REF - log_i.log2) : (log_i.log2 - LOG_REF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
    end else if (adv_o) begin
      d_valid_q <= log_i.valid;
      p_valid_q <= d_valid_q;
    end
  end

  assign prod_d = {{OCT_W{1'b0}}, d_q} * {{LOG_W{1'b0}}, DB_PER_OCTAVE_Q28};

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      d_silent_q <= log_i.silent;
      d_neg_q    <= neg_d;
      d_q        <= dist_d;
      p_silent_q <= d_silent_q;
      p_neg_q    <= d_neg_q;
      p_q        <= prod_d;
    end
  end

  // Round half away from zero: round the magnitude, then apply the sign.
  always_comb begin
    rsum = {1'b0, p_q} + ((PROD_W+1)'(1) << (DB_SHIFT - 1));
    rsh  = rsum >> DB_SHIFT;
    rmag = rsh[LEVEL_W-1:0];
    if (p_silent_q) begin
      level_d = SILENT_LEVEL;
    end else if (p_neg_q) begin
      level_d = LEVEL_W'(0) - rmag;
    end else begin
      level_d = rmag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && p_valid_q) begin
      out_level_q  <= level_d;
      out_silent_q <= p_silent_q;
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_level_o  = out_level_q;
  assign m_silent_o = out_silent_q;

endmodule

>>> rtl/pcm_peak_level_meter_unit.sv
// Channel   Dir  Beat contents
// s_axis    in   tdata[31:0] raw sample word, tlast = last sample of buffer
// m_axis    out  tdata[15:0] level in dBFS (signed, 1/256 dB), tuser = silent
// cfg       in   cfg_data_i[1:0] sample format
//
// One sample per cycle sustained unless the output stalls. After the last
// sample of a buffer is taken, its level passes the peak, leading-one and
// shift registers, the 24 log2 squaring stages, then distance, scale, output.
// Reset clears the peak, all stage valid bits and selects int16 format.
// The pipeline holds only when a finished level meets a full, stalled output
// register; until then samples keep being taken.
module pcm_peak_level_meter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pplm_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pplm_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [31:0] sample_bits
  input  logic                          s_axis_tlast,  // last_in_buffer
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pplm_pkg::LEVEL_W-1:0]  m_axis_tdata,  // [15:0] level_db
  output logic                          m_axis_tuser   // [0] is_silent
);
  import pplm_pkg::*;

  fmt_e fmt_q;
  logic adv;
  job_t job;
  log_t lg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RESET;
    end else if (cfg_valid_i) begin
      fmt_q <= fmt_e'(cfg_data_i);
    end
  end

  assign s_axis_tready = adv;

  pplm_peak u_peak (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .s_valid_i (s_axis_tvalid),
    .s_data_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .fmt_i     (fmt_q),
    .job_o     (job)
  );

  pplm_log2 u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .job_i  (job),
    .log_o  (lg)
  );

  pplm_db u_db (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .log_i      (lg),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_level_o  (m_axis_tdata),
    .m_silent_o (m_axis_tuser),
    .adv_o      (adv)
  );

  // A silent beat always carries the floor level.
  a_silent_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == SILENT_LEVEL))
    else $error("silent beat without floor level");

  // Input is only held off by a stalled output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while output free");

  // A new buffer-end job never appears while the pipeline is frozen.
  a_job_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(adv) && !$past(job.valid)) |-> !job.valid)
    else $error("job launched during stall");

endmodule
